FILE: hdl/fcr_pkg.sv
package fcr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;

  // CRC-8, MSB first
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Valve positions wrap at six; reciprocal for the remainder
  localparam int unsigned VALVE_COUNT = 6;
  localparam logic [16:0] VALVE_RECIP = 17'((65536 + VALVE_COUNT - 1) / VALVE_COUNT);

  // Command codes
  localparam logic [7:0] CMD_START    = 8'h81;
  localparam logic [7:0] CMD_STOP     = 8'h82;
  localparam logic [7:0] CMD_CHANNEL  = 8'h83;
  localparam logic [7:0] CMD_OVERTONE = 8'h84;
  localparam logic [7:0] CMD_TEMP     = 8'h85;
  localparam logic [7:0] CMD_PUMP     = 8'h86;
  localparam logic [7:0] CMD_VALVE    = 8'h87;
  localparam logic [7:0] CMD_CALIB    = 8'h88;
  localparam logic [7:0] CMD_EXPER    = 8'h89;
  localparam logic [7:0] CMD_STATUS   = 8'h8A;
  localparam logic [7:0] CMD_PARAMS   = 8'h8B;
  localparam logic [7:0] CMD_LINK     = 8'h8C;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_e;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_START,
    EV_STOP,
    EV_CHANNEL,
    EV_OVERTONE,
    EV_TEMP,
    EV_PUMP,
    EV_VALVE,
    EV_CALIB,
    EV_EXPER,
    EV_STATUS,
    EV_PARAMS
  } event_e;

  typedef struct packed {
    logic        channel;
    logic [2:0]  overtone;
    logic        run_sweep;
    logic [31:0] temp;
    logic [31:0] pump;
    logic [2:0]  valve;
    logic [31:0] duration;
    logic [7:0]  link;
  } settings_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Remainder of a byte by a small count (1..8); recip is ceil(2^16 / n)
  function automatic logic [2:0] mod_small(logic [7:0] b, logic [3:0] n, logic [16:0] recip);
    logic [24:0] prod;
    logic [7:0]  q;
    logic [11:0] qn;
    prod = 25'(b) * 25'(recip);
    q    = prod[23:16];
    qn   = 12'(q) * 12'(n);
    return 3'(b - qn[7:0]);
  endfunction

endpackage

FILE: hdl/fcr_ifs.sv
interface fcr_rx_if import fcr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcr_res_if import fcr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [3:0]  event_res;
  logic        channel;
  logic [2:0]  overtone;
  logic        run_sweep;
  logic [31:0] target_temp_bits;
  logic [31:0] pump_rate_bits;
  logic [2:0]  valve_position;
  logic [31:0] duration_seconds;
  logic [7:0]  link_connected;

  modport source (
    output valid, output crc_ok, output event_res, output channel, output overtone,
    output run_sweep, output target_temp_bits, output pump_rate_bits,
    output valve_position, output duration_seconds, output link_connected,
    input ready
  );
  modport sink (
    input valid, input crc_ok, input event_res, input channel, input overtone,
    input run_sweep, input target_temp_bits, input pump_rate_bits,
    input valve_position, input duration_seconds, input link_connected,
    output ready
  );
endinterface

FILE: hdl/framed_command_receiver.sv
// Channel  Dir  Handshake          Word
// rx_i     in   valid/ready        rx_byte: one received byte
// res_o    out  valid/ready        CRC status, event code, current settings
// cfg      in   cfg_we_i (no wait) cfg_idx_i selects sync_first / sync_second
//
// One byte is taken per cycle; tracker, CRC-8 update and command decode all
// settle in the cycle the byte is accepted.
// A result appears in the cycle after its CRC byte is accepted and holds in the
// output register until taken; only a CRC byte waits behind a full register.
// Reset (rst_ni low, async) starts the sync hunt with all settings zero and
// the sync bytes at 0xA5 / 0x5A.
module framed_command_receiver import fcr_pkg::*; #(
  parameter int unsigned MAX_LEN        = 250,
  parameter int unsigned OVERTONE_COUNT = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  fcr_rx_if.sink               rx_i,
  fcr_res_if.source            res_o
);

  localparam logic [7:0]  MaxLen        = 8'(MAX_LEN);
  localparam logic [3:0]  OvertoneN     = 4'(OVERTONE_COUNT);
  localparam logic [16:0] OvertoneRecip =
    17'((65536 + OVERTONE_COUNT - 1) / OVERTONE_COUNT);
  localparam logic [3:0]  ValveN        = 4'(VALVE_COUNT);

  // Configuration
  logic [7:0] sync_first_q, sync_second_q;

  // Frame tracker
  phase_e     phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [2:0] cnt_q, cnt_d;    // payload bytes seen, saturates at four
  logic [7:0] crc_q, crc_d;
  logic [31:0] word_q, word_d;

  // Settings
  settings_t set_q, set_d;

  // Output register
  logic      res_valid_q;
  logic      res_ok_q;
  event_e    res_event_q;
  settings_t res_set_q;

  logic       accept;
  logic       res_load;
  logic       crc_match;
  event_e     ev;
  logic [7:0] b;
  logic [7:0] ot_src;
  logic [2:0] ot_mod, valve_mod;

  assign b = rx_i.rx_byte;

  // Only a CRC byte makes a result, so only it waits for a free output register
  assign rx_i.ready = !res_valid_q || res_o.ready || (phase_q != PH_CRC);
  assign accept     = rx_i.valid && rx_i.ready;
  assign res_load   = accept && (phase_q == PH_CRC);
  assign crc_match  = (b == crc_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_SYNC2: begin
          if (b == sync_second_q) begin
            phase_d = PH_CMD;
          end else if (b == sync_first_q) begin
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_CMD: phase_d = PH_LEN;
        PH_LEN: begin
          if (b > MaxLen) begin
            phase_d = PH_SYNC1;    // drop oversized frame
          end else if (b != 8'd0) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_CRC;
          end
        end
        PH_DATA: phase_d = (len_q == 8'd1) ? PH_CRC : PH_DATA;
        PH_CRC:  phase_d = PH_SYNC1;  // hunt again, no rescan
        default: phase_d = (b == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  // Remainders for overtone and valve selections
  assign ot_src    = (cmd_q == CMD_START) ? word_q[15:8] : word_q[7:0];
  assign ot_mod    = mod_small(ot_src, OvertoneN, OvertoneRecip);
  assign valve_mod = mod_small(word_q[7:0], ValveN, VALVE_RECIP);

  // Frame datapath and command decode
  always_comb begin
    cmd_d  = cmd_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    word_d = word_q;
    set_d  = set_q;
    ev     = EV_NONE;
    if (accept) begin
      case (phase_q)
        PH_CMD: begin
          cmd_d = b;
          crc_d = crc8_byte(8'd0, b);
        end
        PH_LEN: begin
          if (b <= MaxLen) begin
            crc_d  = crc8_byte(crc_q, b);
            len_d  = b;
            cnt_d  = 3'd0;
            word_d = '0;
          end
        end
        PH_DATA: begin
          crc_d = crc8_byte(crc_q, b);
          if (cnt_q != 3'd4) begin
            word_d[{cnt_q[1:0], 3'b000} +: 8] = b;
            cnt_d = cnt_q + 3'd1;
          end
          len_d = len_q - 8'd1;
        end
        PH_CRC: begin
          if (crc_match) begin
            case (cmd_q)
              CMD_START: begin
                ev = EV_START;
                if (cnt_q >= 3'd1) set_d.channel   = word_q[0];
                if (cnt_q >= 3'd2) set_d.overtone  = ot_mod;
                if (cnt_q >= 3'd3) set_d.run_sweep = word_q[16];
              end
              CMD_STOP: ev = EV_STOP;
              CMD_CHANNEL: begin
                ev = EV_CHANNEL;
                if (cnt_q >= 3'd1) set_d.channel = word_q[0];
              end
              CMD_OVERTONE: begin
                ev = EV_OVERTONE;
                if (cnt_q >= 3'd1) set_d.overtone = ot_mod;
              end
              CMD_TEMP: begin
                ev = EV_TEMP;
                if (cnt_q == 3'd4) set_d.temp = word_q;
              end
              CMD_PUMP: begin
                ev = EV_PUMP;
                if (cnt_q == 3'd4) set_d.pump = word_q;
              end
              CMD_VALVE: begin
                ev = EV_VALVE;
                if (cnt_q >= 3'd1) set_d.valve = valve_mod;
              end
              CMD_CALIB: ev = EV_CALIB;
              CMD_EXPER: begin
                ev = EV_EXPER;
                if (cnt_q == 3'd4) set_d.duration = word_q;
              end
              CMD_STATUS: ev = EV_STATUS;
              CMD_PARAMS: ev = EV_PARAMS;   // report only, no settings copy
              CMD_LINK: begin
                if (cnt_q >= 3'd1) set_d.link = word_q[7:0];
              end
              default: ev = EV_NONE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= '0;
      word_q  <= '0;
      set_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      word_q  <= word_d;
      set_q   <= set_d;
    end
  end

  // Output register: load on the CRC byte, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_ok_q    <= crc_match;
      res_event_q <= ev;
      res_set_q   <= set_d;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.crc_ok           = res_ok_q;
  assign res_o.event_res        = res_event_q;
  assign res_o.channel          = res_set_q.channel;
  assign res_o.overtone         = res_set_q.overtone;
  assign res_o.run_sweep        = res_set_q.run_sweep;
  assign res_o.target_temp_bits = res_set_q.temp;
  assign res_o.pump_rate_bits   = res_set_q.pump;
  assign res_o.valve_position   = res_set_q.valve;
  assign res_o.duration_seconds = res_set_q.duration;
  assign res_o.link_connected   = res_set_q.link;

  // Checks
  a_crc_byte_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q)
    else $error("result not loaded after CRC byte");

  a_crc_byte_restarts_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (phase_q == PH_SYNC1))
    else $error("hunt not restarted after CRC byte");

  a_bad_crc_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ok_q) |-> (res_event_q == EV_NONE))
    else $error("event reported for a discarded frame");

  a_settings_only_on_good_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_load && crc_match) |=> (set_q == $past(set_q)))
    else $error("settings changed without a good frame");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb import fcr_pkg::*; ();

  localparam int unsigned MAX_LEN        = 250;
  localparam int unsigned OVERTONE_COUNT = 6;
  localparam int unsigned RANDOM_BYTES   = 880;
  localparam int unsigned CFG_INTERVAL   = 160;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  // One expected result word: CRC status, event and the settings after the frame
  typedef struct {
    logic      crc_ok;
    event_e    ev;
    settings_t set;
  } frame_res_t;

  // One stimulus row: a frame with optional leading noise, maybe cut short
  typedef struct {
    logic [1:0][7:0] lead;
    int              lead_n;
    bit              extra_sync;
    logic [7:0]      cmd;
    logic [7:0]      len;
    logic [31:0]     head;
    bit              bad_crc;
    bit              truncate;
    bit              typed;
    frame_res_t      want;
  } frame_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;

  fcr_rx_if  rx_if ();
  fcr_res_if res_if ();

  framed_command_receiver #(
    .MAX_LEN        (MAX_LEN),
    .OVERTONE_COUNT (OVERTONE_COUNT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame tracker: own copy of the receiver state, advanced once per accepted
  // byte, plus the sync bytes as last written through the config port.
  // ---------------------------------------------------------------------------
  logic [7:0]  trk_sync1 = SYNC_FIRST_RST;
  logic [7:0]  trk_sync2 = SYNC_SECOND_RST;
  phase_e      trk_phase = PH_SYNC1;
  logic [7:0]  trk_cmd   = '0;
  logic [7:0]  trk_left  = '0;
  logic [7:0]  trk_count = '0;
  logic [7:0]  trk_crc   = '0;
  logic [31:0] trk_word  = '0;
  settings_t   cur_set   = '0;

  frame_res_t  pending_res [$];   // expected result words, oldest first
  int          err_cnt   = 0;
  int          cycle_cnt = 0;
  int          bytes_sent = 0;

  // Driver side: current sync bytes used to build frames, gap mode, and the
  // typed-in expectation that rides along with a byte
  logic [7:0]  tx_sync1 = SYNC_FIRST_RST;
  logic [7:0]  tx_sync2 = SYNC_SECOND_RST;
  bit          tx_burst = 1'b0;
  bit          rx_use_typed = 1'b0;
  frame_res_t  rx_typed_res;

  // CRC-8, polynomial 0x07, MSB first
  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Apply a frame with good CRC to the settings; return its event code
  function automatic event_e decode_command();
    logic [7:0] b0, b1, b2;
    b0 = trk_word[7:0];
    b1 = trk_word[15:8];
    b2 = trk_word[23:16];
    case (trk_cmd)
      CMD_START: begin
        if (trk_count >= 1) cur_set.channel = b0[0];
        if (trk_count >= 2) cur_set.overtone = 3'(b1 % OVERTONE_COUNT);
        if (trk_count >= 3) cur_set.run_sweep = b2[0];
        return EV_START;
      end
      CMD_STOP: return EV_STOP;
      CMD_CHANNEL: begin
        if (trk_count >= 1) cur_set.channel = b0[0];
        return EV_CHANNEL;
      end
      CMD_OVERTONE: begin
        if (trk_count >= 1) cur_set.overtone = 3'(b0 % OVERTONE_COUNT);
        return EV_OVERTONE;
      end
      CMD_TEMP: begin
        if (trk_count >= 4) cur_set.temp = trk_word;
        return EV_TEMP;
      end
      CMD_PUMP: begin
        if (trk_count >= 4) cur_set.pump = trk_word;
        return EV_PUMP;
      end
      CMD_VALVE: begin
        if (trk_count >= 1) cur_set.valve = 3'(b0 % VALVE_COUNT);
        return EV_VALVE;
      end
      CMD_CALIB: return EV_CALIB;
      CMD_EXPER: begin
        if (trk_count >= 4) cur_set.duration = trk_word;
        return EV_EXPER;
      end
      CMD_STATUS: return EV_STATUS;
      CMD_PARAMS: return EV_PARAMS;
      CMD_LINK: begin
        if (trk_count >= 1) cur_set.link = b0;
        return EV_NONE;
      end
      default: return EV_NONE;
    endcase
  endfunction

  // Advance the tracker by one byte; return 1 with the result word on a CRC byte
  function automatic bit track_frame(input logic [7:0] b, output frame_res_t r);
    r.crc_ok = 1'b0;
    r.ev     = EV_NONE;
    r.set    = cur_set;
    case (trk_phase)
      PH_SYNC2: begin
        if (b == trk_sync2) trk_phase = PH_CMD;
        else if (b == trk_sync1) trk_phase = PH_SYNC2;
        else trk_phase = PH_SYNC1;
      end
      PH_CMD: begin
        trk_cmd   = b;
        trk_crc   = crc8_next(8'h00, b);
        trk_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b > MAX_LEN) begin
          trk_phase = PH_SYNC1;
        end else begin
          trk_crc   = crc8_next(trk_crc, b);
          trk_left  = b;
          trk_count = '0;
          trk_word  = '0;
          trk_phase = (b != 0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        trk_crc = crc8_next(trk_crc, b);
        if (trk_count < 4) trk_word |= 32'(b) << (8 * trk_count);
        if (trk_count != 8'hFF) trk_count++;
        trk_left--;
        if (trk_left == 0) trk_phase = PH_CRC;
      end
      PH_CRC: begin
        r.crc_ok  = (b == trk_crc);
        r.ev      = r.crc_ok ? decode_command() : EV_NONE;
        r.set     = cur_set;
        trk_phase = PH_SYNC1;
        return 1'b1;
      end
      default: trk_phase = (b == trk_sync1) ? PH_SYNC2 : PH_SYNC1;
    endcase
    return 1'b0;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track accepted bytes and config writes, check result words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    frame_res_t pred, want;
    if (rst_ni) begin
      cycle_cnt++;
      if (rx_if.valid && rx_if.ready) begin
        if (track_frame(rx_if.rx_byte, pred)) begin
          pending_res.push_back(rx_use_typed ? rx_typed_res : pred);
        end
      end
      // a write lands at this edge and governs the bytes after it
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SYNC_FIRST) trk_sync1 = cfg_wdata_i;
        else if (cfg_idx_i == CFG_SYNC_SECOND) trk_sync2 = cfg_wdata_i;
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_res.size() == 0) begin
          $error("result word with no frame pending");
          err_cnt++;
        end else begin
          want = pending_res.pop_front();
          cmp_field("crc_ok", 32'(want.crc_ok), 32'(res_if.crc_ok));
          cmp_field("event_res", 32'(want.ev), 32'(res_if.event_res));
          cmp_field("channel", 32'(want.set.channel), 32'(res_if.channel));
          cmp_field("overtone", 32'(want.set.overtone), 32'(res_if.overtone));
          cmp_field("run_sweep", 32'(want.set.run_sweep), 32'(res_if.run_sweep));
          cmp_field("target_temp_bits", want.set.temp, res_if.target_temp_bits);
          cmp_field("pump_rate_bits", want.set.pump, res_if.pump_rate_bits);
          cmp_field("valve_position", 32'(want.set.valve), 32'(res_if.valve_position));
          cmp_field("duration_seconds", want.set.duration, res_if.duration_seconds);
          cmp_field("link_connected", 32'(want.set.link), 32'(res_if.link_connected));
        end
      end
    end
  end

  // Watchdog: end the run if the cycle count runs away
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("[framed_command_receiver] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: hold ready high for runs, drop it for random gaps; now and
  // then leave it open for a long stretch
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (tx_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  initial begin : res_sink
    int n_on, n_off, r;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      repeat (n_on - 1) @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 50) n_off = 0;
      else if (r < 88) n_off = $urandom_range(1, 3);
      else if (r < 97) n_off = $urandom_range(4, 12);
      else n_off = $urandom_range(13, 40);
      if (n_off > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (n_off - 1) @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap and hold it until the receiver takes it
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_use_typed  = typed;
    rx_typed_res  = want;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  function automatic frame_res_t mk_res(logic ok, event_e ev, logic [31:0] temp,
                                        logic [31:0] dur);
    frame_res_t r;
    r.crc_ok       = ok;
    r.ev           = ev;
    r.set          = '0;
    r.set.temp     = temp;
    r.set.duration = dur;
    return r;
  endfunction

  function automatic frame_row_t mk_row(logic [7:0] cmd, logic [7:0] len, logic [31:0] head,
                                        bit bad);
    frame_row_t r;
    r.lead       = '0;
    r.lead_n     = 0;
    r.extra_sync = 1'b0;
    r.cmd        = cmd;
    r.len        = len;
    r.head       = head;
    r.bad_crc    = bad;
    r.truncate   = 1'b0;
    r.typed      = 1'b0;
    r.want       = mk_res(1'b0, EV_NONE, '0, '0);
    return r;
  endfunction

  // Build the byte sequence of one row, then send it
  task automatic send_frame(input frame_row_t fr);
    logic [7:0] q [$];
    logic [7:0] crc, d;
    int         n;
    for (int i = 0; i < fr.lead_n; i++) q.push_back(fr.lead[i]);
    q.push_back(tx_sync1);
    if (fr.extra_sync) q.push_back(tx_sync1);
    q.push_back(tx_sync2);
    q.push_back(fr.cmd);
    q.push_back(fr.len);
    // an oversized length ends the frame right there
    if (fr.len <= MAX_LEN) begin
      crc = crc8_next(crc8_next(8'h00, fr.cmd), fr.len);
      for (int i = 0; i < fr.len; i++) begin
        d = (i < 4) ? fr.head[8*i +: 8] : 8'($urandom);
        q.push_back(d);
        crc = crc8_next(crc, d);
      end
      if (fr.bad_crc) crc ^= 8'(1 << $urandom_range(0, 7));
      q.push_back(crc);
    end
    if (fr.truncate) begin
      n = $urandom_range(1, q.size() - 1);
      while (q.size() > n) void'(q.pop_back());
    end
    for (int i = 0; i < q.size(); i++) begin
      send_byte(q[i], fr.typed && (i == q.size() - 1), fr.want);
    end
  endtask

  // Stop offering bytes, drain all pending results, then let the pipe settle
  task automatic settle_idle(input int n);
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic set_syncs(input logic [7:0] first, input logic [7:0] second);
    settle_idle(4);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_FIRST;
    cfg_wdata_i <= first;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SYNC_SECOND;
    cfg_wdata_i <= second;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tx_sync1 = first;
    tx_sync2 = second;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    frame_row_t dir_rows [$];
    frame_row_t row;
    logic [7:0] cfg_a [5];
    logic [7:0] cfg_b [5];
    int         cfg_k, next_cfg, r, len;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SYNC_FIRST;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    rx_typed_res  = mk_res(1'b0, EV_NONE, '0, '0);

    // Directed table. The first rows carry typed-in results: a bad CRC right
    // after reset, then all-ones words into temperature and duration.
    row = mk_row(CMD_TEMP, 8'd4, 32'h1234_5678, 1'b1);
    row.typed = 1'b1;
    row.want  = mk_res(1'b0, EV_NONE, '0, '0);
    dir_rows.push_back(row);
    row = mk_row(CMD_TEMP, 8'd4, 32'hFFFF_FFFF, 1'b0);
    row.typed = 1'b1;
    row.want  = mk_res(1'b1, EV_TEMP, 32'hFFFF_FFFF, '0);
    dir_rows.push_back(row);
    // repeated first sync before the second one
    row = mk_row(CMD_EXPER, 8'd4, 32'hFFFF_FFFF, 1'b0);
    row.extra_sync = 1'b1;
    row.typed = 1'b1;
    row.want  = mk_res(1'b1, EV_EXPER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    dir_rows.push_back(row);
    // the rest goes through the tracker
    dir_rows.push_back(mk_row(CMD_START, 8'd3, 32'h00FF_FFFF, 1'b0));
    dir_rows.push_back(mk_row(CMD_START, 8'd1, 32'h0000_0000, 1'b0));
    dir_rows.push_back(mk_row(CMD_START, 8'd0, 32'h0000_0000, 1'b0));
    dir_rows.push_back(mk_row(CMD_STOP, 8'd0, 32'h0000_0000, 1'b0));
    dir_rows.push_back(mk_row(CMD_CHANNEL, 8'd1, 32'h0000_0001, 1'b0));
    dir_rows.push_back(mk_row(CMD_OVERTONE, 8'd1, 32'h0000_00FF, 1'b0));
    dir_rows.push_back(mk_row(CMD_OVERTONE, 8'd2, 32'h0000_0005, 1'b0));
    dir_rows.push_back(mk_row(CMD_PUMP, 8'd3, 32'h00FF_FFFF, 1'b0));
    dir_rows.push_back(mk_row(CMD_PUMP, 8'd5, 32'hAABB_CCDD, 1'b0));
    dir_rows.push_back(mk_row(CMD_VALVE, 8'd1, 32'h0000_00FF, 1'b0));
    dir_rows.push_back(mk_row(CMD_VALVE, 8'd1, 32'h0000_0005, 1'b0));
    dir_rows.push_back(mk_row(CMD_CALIB, 8'd2, 32'h0000_1234, 1'b0));
    dir_rows.push_back(mk_row(CMD_STATUS, 8'd0, 32'h0000_0000, 1'b0));
    dir_rows.push_back(mk_row(CMD_PARAMS, 8'd8, 32'h0102_0304, 1'b0));
    dir_rows.push_back(mk_row(CMD_LINK, 8'd1, 32'h0000_00FF, 1'b0));
    dir_rows.push_back(mk_row(CMD_LINK, 8'd0, 32'h0000_0000, 1'b0));
    // unknown commands at both ends of the byte range
    dir_rows.push_back(mk_row(8'h00, 8'd1, 32'h0000_0001, 1'b0));
    dir_rows.push_back(mk_row(8'hFF, 8'd2, 32'h0000_FFFF, 1'b0));
    // longest legal payload, preceded by a lone first sync and a stray byte
    row = mk_row(CMD_EXPER, 8'(MAX_LEN), 32'h0000_0000, 1'b0);
    row.lead   = {8'h00, SYNC_FIRST_RST};
    row.lead_n = 2;
    dir_rows.push_back(row);
    // oversized lengths: dropped without a result
    dir_rows.push_back(mk_row(CMD_TEMP, 8'(MAX_LEN + 1), 32'h0, 1'b0));
    dir_rows.push_back(mk_row(CMD_CHANNEL, 8'hFF, 32'h0, 1'b0));
    // empty payload with a bad CRC, after noise that looks like the second sync
    row = mk_row(CMD_TEMP, 8'd0, 32'h0, 1'b1);
    row.lead   = {8'hFF, SYNC_SECOND_RST};
    row.lead_n = 2;
    dir_rows.push_back(row);

    // sync settings for the random phases, extremes first
    cfg_a[0] = 8'h00;           cfg_b[0] = 8'hFF;
    cfg_a[1] = 8'hFF;           cfg_b[1] = 8'h00;
    cfg_a[2] = 8'h3C;           cfg_b[2] = 8'h3C;
    cfg_a[3] = 8'($urandom);    cfg_b[3] = 8'($urandom);
    cfg_a[4] = SYNC_FIRST_RST;  cfg_b[4] = SYNC_SECOND_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      tx_burst = ($urandom_range(0, 5) == 0);
      send_frame(dir_rows[i]);
    end

    // Random part: mostly well-formed frames with random content, the rest
    // noise, cut frames, oversized lengths and a broken sync pair
    bytes_sent = 0;
    next_cfg   = CFG_INTERVAL;
    cfg_k      = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= next_cfg && cfg_k < 5) begin
        set_syncs(cfg_a[cfg_k], cfg_b[cfg_k]);
        cfg_k++;
        next_cfg += CFG_INTERVAL;
      end
      tx_burst = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 80 || r >= 88) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(0, 6);
        else if (r < 98) len = $urandom_range(7, 20);
        else len = $urandom_range(21, MAX_LEN);
        row = mk_row(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                 : 8'(CMD_START + $urandom_range(0, 11)),
                     8'(len), $urandom, ($urandom_range(0, 9) == 0));
        row.extra_sync = ($urandom_range(0, 9) == 0);
        row.lead       = 16'($urandom);
        row.lead_n     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        r = $urandom_range(0, 99);
        if (r < 8) row.truncate = 1'b1;
        else if (r < 14) row.len = 8'($urandom_range(MAX_LEN + 1, 255));
        send_frame(row);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, rx_typed_res);
      end else begin
        // first sync followed by a byte that is most likely not the second
        send_byte(tx_sync1, 1'b0, rx_typed_res);
        send_byte(8'($urandom), 1'b0, rx_typed_res);
      end
    end

    settle_idle(8);
    if (err_cnt == 0) begin
      $display("[framed_command_receiver] OK");
    end else begin
      $display("[framed_command_receiver] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fcr_pkg.sv
hdl/fcr_ifs.sv
hdl/framed_command_receiver.sv
tb/tb.sv
